// ----- hw/rtl/frcv_pkg.sv -----
// Shared types, codes and CRC byte-update functions for the fragment receiver.
// Used by fragment_receiver_crc_verify and its bound checker frcv_check.
`timescale 1ns / 1ps

package frcv_pkg;

    // Command codes carried on the input tuser
    localparam logic [1:0] CMD_SIZE  = 2'd0;
    localparam logic [1:0] CMD_FCRC  = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_CHECK = 2'd3;

    // Reply codes sent back to the partner
    localparam logic [1:0] REPLY_NONE    = 2'd0;
    localparam logic [1:0] REPLY_APPROVE = 2'd1;
    localparam logic [1:0] REPLY_REJECT  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_SIZE_OK  = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE = 3'd1;
    localparam logic [2:0] ST_CSUM_OK  = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM = 3'd3;
    localparam logic [2:0] ST_FRAG_OK  = 3'd4;
    localparam logic [2:0] ST_FRAG_BAD = 3'd5;
    localparam logic [2:0] ST_TRIES    = 3'd6;
    localparam logic [2:0] ST_DONE     = 3'd7;

    // CRC constants
    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFF_FFFF;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;

    localparam logic [7:0] MAX_TRIES_RST = 8'd5;

    // Result queue sizing
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    typedef enum logic [2:0] {
        M_SIZE,
        M_FCRC,
        M_DATA,
        M_DONE,
        M_FAILED
    } t_mode;

    typedef struct packed {
        logic [1:0] reply;
        logic [2:0] status;
        logic       last;
    } t_result;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC-16/CCITT, MSB first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fragment_receiver_crc_verify.sv -----
// Channel      | dir | signals                         | contents
// s (items)    | in  | i_s_tvalid/o_s_tready/tdata/tuser | byte, value; tuser = command
// m (results)  | out | o_m_tvalid/i_m_tready/tdata/tlast | reply, status; tlast = last
// cfg          | in  | i_cfg_valid/o_cfg_ready/i_cfg_data | max_tries
//
// On each accepted input word the mode, CRC and retry registers update at
// the accepting edge, and the zero, one or two results land in a four-entry result
// queue. A word is accepted every cycle while the queue holds at most two results;
// results leave one per cycle while i_m_tready is high; queue depth sets how far output may stall.
// Reset (synchronous, active low) returns to waiting for the size header.
// Stop-and-wait receiver: header checks, per-fragment CRC-16, whole-file CRC-32.
// Depends on frcv_pkg.
`timescale 1ns / 1ps

module fragment_receiver_crc_verify
    import frcv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] data_byte, [39:8] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    // result words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [1:0] reply, [4:2] status, [7:5] zero
    output logic        o_m_tlast,   // last
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data   // max_tries
);

    t_mode       r_mode, n_mode;
    logic [31:0] r_exp_crc, n_exp_crc;
    logic [31:0] r_comm_crc, n_comm_crc;
    logic [31:0] r_tent_crc, n_tent_crc;
    logic [15:0] r_frag_crc, n_frag_crc;
    logic [7:0]  r_retry, n_retry;
    logic [7:0]  r_max_tries;

    t_result          r_q_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [RQ_CW-1:0] r_count;

    logic        w_accept, w_pop;
    logic [1:0]  w_cmd;
    logic [7:0]  w_byte;
    logic [31:0] w_value;
    logic        w_frag_match, w_file_done, w_retry_fail;
    logic [7:0]  w_retry_inc;
    logic [1:0]  n_push;
    t_result     n_res0, n_res1;
    t_result     w_head;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_cmd    = i_s_tuser;
    assign w_byte   = i_s_tdata[7:0];
    assign w_value  = i_s_tdata[39:8];

    assign w_frag_match = (w_value == {16'h0000, r_frag_crc});
    assign w_file_done  = ((r_tent_crc ^ CRC32_INIT) == r_exp_crc);
    assign w_retry_inc  = (r_retry != 8'hFF) ? (r_retry + 8'd1) : r_retry;
    assign w_retry_fail = (w_retry_inc >= r_max_tries);

    // Next mode
    always_comb begin
        n_mode = r_mode;
        if (w_accept) begin
            unique case (w_cmd)
                CMD_SIZE: begin
                    if (r_mode == M_SIZE) n_mode = (w_value == 32'h0) ? M_FAILED : M_FCRC;
                end
                CMD_FCRC: begin
                    if (r_mode == M_FCRC) n_mode = (w_value == 32'h0) ? M_FAILED : M_DATA;
                end
                CMD_BYTE: begin
                    n_mode = r_mode;
                end
                CMD_CHECK: begin
                    if (r_mode == M_DATA) begin
                        if (w_frag_match && w_file_done)       n_mode = M_DONE;
                        else if (!w_frag_match && w_retry_fail) n_mode = M_FAILED;
                    end
                end
                default: n_mode = r_mode;
            endcase
        end
    end

    // Datapath updates and results
    always_comb begin
        n_exp_crc  = r_exp_crc;
        n_comm_crc = r_comm_crc;
        n_tent_crc = r_tent_crc;
        n_frag_crc = r_frag_crc;
        n_retry    = r_retry;
        n_push     = 2'd0;
        n_res0     = '{reply: REPLY_NONE, status: ST_SIZE_OK, last: 1'b1};
        n_res1     = '{reply: REPLY_NONE, status: ST_SIZE_OK, last: 1'b1};
        if (w_accept) begin
            unique case (w_cmd)
                CMD_SIZE: begin
                    if (r_mode == M_SIZE) begin
                        n_push = 2'd1;
                        n_res0.status = (w_value == 32'h0) ? ST_BAD_SIZE : ST_SIZE_OK;
                    end
                end
                CMD_FCRC: begin
                    if (r_mode == M_FCRC) begin
                        n_push = 2'd1;
                        if (w_value == 32'h0) begin
                            n_res0.status = ST_BAD_CSUM;
                        end else begin
                            n_exp_crc     = w_value;
                            n_res0.reply  = REPLY_APPROVE;
                            n_res0.status = ST_CSUM_OK;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (r_mode == M_DATA) begin
                        n_tent_crc = crc32_byte(r_tent_crc, w_byte);
                        n_frag_crc = crc16_byte(r_frag_crc, w_byte);
                    end
                end
                CMD_CHECK: begin
                    if (r_mode == M_DATA) begin
                        n_frag_crc = CRC16_INIT;
                        if (w_frag_match) begin
                            // commit the fragment
                            n_comm_crc    = r_tent_crc;
                            n_retry       = 8'd0;
                            n_res0.reply  = REPLY_APPROVE;
                            n_res0.status = ST_FRAG_OK;
                            n_res1.reply  = REPLY_APPROVE;
                            n_res1.status = ST_DONE;
                            n_res0.last   = !w_file_done;
                            n_push        = w_file_done ? 2'd2 : 2'd1;
                        end else begin
                            // drop the fragment, roll back the file CRC
                            n_tent_crc    = r_comm_crc;
                            n_retry       = w_retry_inc;
                            n_res0.reply  = REPLY_REJECT;
                            n_res0.status = ST_FRAG_BAD;
                            n_res1.status = ST_TRIES;
                            n_res0.last   = !w_retry_fail;
                            n_push        = w_retry_fail ? 2'd2 : 2'd1;
                        end
                    end
                end
                default: n_push = 2'd0;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_SIZE;
            r_exp_crc   <= 32'h0;
            r_comm_crc  <= CRC32_INIT;
            r_tent_crc  <= CRC32_INIT;
            r_frag_crc  <= CRC16_INIT;
            r_retry     <= 8'd0;
            r_max_tries <= MAX_TRIES_RST;
        end else begin
            r_mode     <= n_mode;
            r_exp_crc  <= n_exp_crc;
            r_comm_crc <= n_comm_crc;
            r_tent_crc <= n_tent_crc;
            r_frag_crc <= n_frag_crc;
            r_retry    <= n_retry;
            if (i_cfg_valid && o_cfg_ready) r_max_tries <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Result queue: push up to two, pop one
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tvalid = (r_count != '0);
    assign o_s_tready = (r_count <= RQ_CW'(RQ_DEPTH - 2));
    assign w_head     = r_q_mem[r_rd_ptr];
    assign o_m_tdata  = {3'b000, w_head.status, w_head.reply};
    assign o_m_tlast  = w_head.last;

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) r_q_mem[r_wr_ptr] <= n_res0;
        if (n_push == 2'd2) r_q_mem[r_wr_ptr + RQ_AW'(1)] <= n_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RQ_AW'(n_push);
            if (w_pop) r_rd_ptr <= r_rd_ptr + RQ_AW'(1);
            r_count  <= r_count + RQ_CW'(n_push) - RQ_CW'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/frcv_check.sv -----
// Port-level checker for fragment_receiver_crc_verify, attached by bind.
// Depends on frcv_pkg.
`timescale 1ns / 1ps

module frcv_check
    import frcv_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    // no reply code beyond reject
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("undefined reply code");

    // a non-final result is followed by its partner already queued
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("second result of a pair missing");

    // fragment bytes never produce results
    a_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == CMD_BYTE && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result appeared after a fragment byte");

endmodule

bind fragment_receiver_crc_verify frcv_check u_frcv_check (.*);

// ----- tb/fragment_receiver_crc_verify_tb.sv -----
// Self-checking testbench for fragment_receiver_crc_verify: directed and random
// header and fragment streams, result words checked against an in-bench predictor.
// Depends on frcv_pkg and the fragment_receiver_crc_verify RTL.
`timescale 1ns / 1ps

module fragment_receiver_crc_verify_tb
    import frcv_pkg::*;
();

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_MAX    = 10;

    // How a generated fragment claims its CRC-16
    localparam int FRAG_GOOD = 0;
    localparam int FRAG_FLIP = 1;
    localparam int FRAG_WIDE = 2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_b;
        logic [31:0] value;
    } t_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;      // [7:0] data_byte, [39:8] value
    logic [1:0]  i_s_tuser   = '0;      // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;             // [1:0] reply, [4:2] status, [7:5] zero
    logic        o_m_tlast;             // last
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data  = MAX_TRIES_RST;

    // Receiver state as predicted from the accepted words
    t_mode       rx_mode         = M_SIZE;
    logic [31:0] file_crc_exp    = '0;
    logic [31:0] crc32_committed = CRC32_INIT;
    logic [31:0] crc32_running   = CRC32_INIT;
    logic [15:0] crc16_frag      = CRC16_INIT;
    logic [7:0]  reject_run      = '0;
    logic [7:0]  tries_cfg       = MAX_TRIES_RST;

    t_word       pending_words[$];
    t_result     expected_replies[$];
    logic [7:0]  frag_bytes[$];
    int          words_queued = 0;
    int          words_taken  = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;

    t_word       tx_word;
    int          tx_gap   = 0;
    int          tx_quiet = 0;
    int          rx_stall = 0;
    int          rx_quiet = 0;
    int          rx_hold  = 0;
    logic        hold_arm  = 1'b0;
    logic        hold_used = 1'b0;

    fragment_receiver_crc_verify i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            fb = c[0];
            c  = c >> 1;
            if (fb) c = c ^ CRC32_POLY;
        end
        return c;
    endfunction

    // CRC-16/CCITT, one byte, MSB first
    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            fb = c[15];
            c  = c << 1;
            if (fb) c = c ^ CRC16_POLY;
        end
        return c;
    endfunction

    // Four bytes (LSB first in the word) that take the CRC-32 state to target:
    // run 32 shift steps backwards from the target, then cancel the start state.
    function automatic logic [31:0] crc32_steer(logic [31:0] state, logic [31:0] target);
        logic [31:0] x;
        x = target;
        for (int i = 0; i < 32; i++) begin
            if (x[31]) x = ((x ^ CRC32_POLY) << 1) | 32'h1;
            else x = x << 1;
        end
        return x ^ state;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void report_error(string msg);
        error_count++;
        if (error_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endfunction

    // Append one predicted result word
    function automatic void expect_result(t_result r);
        expected_replies.insert(expected_replies.size(), r);
    endfunction

    // Advance the predicted receiver by one accepted word
    function automatic void predict_word(t_word w);
        case (w.cmd)
            CMD_SIZE: begin
                if (rx_mode == M_SIZE) begin
                    if (w.value == 32'h0) begin
                        rx_mode = M_FAILED;
                        expect_result(t_result'{REPLY_NONE, ST_BAD_SIZE, 1'b1});
                    end else begin
                        rx_mode = M_FCRC;
                        expect_result(t_result'{REPLY_NONE, ST_SIZE_OK, 1'b1});
                    end
                end
            end
            CMD_FCRC: begin
                if (rx_mode == M_FCRC) begin
                    if (w.value == 32'h0) begin
                        rx_mode = M_FAILED;
                        expect_result(t_result'{REPLY_NONE, ST_BAD_CSUM, 1'b1});
                    end else begin
                        file_crc_exp = w.value;
                        rx_mode = M_DATA;
                        expect_result(t_result'{REPLY_APPROVE, ST_CSUM_OK, 1'b1});
                    end
                end
            end
            CMD_BYTE: begin
                if (rx_mode == M_DATA) begin
                    crc32_running = crc32_update(crc32_running, w.data_b);
                    crc16_frag    = crc16_update(crc16_frag, w.data_b);
                end
            end
            CMD_CHECK: begin
                if (rx_mode == M_DATA) begin
                    if (w.value == {16'h0, crc16_frag}) begin
                        // Commit the fragment; finish when the whole file matches
                        crc32_committed = crc32_running;
                        crc16_frag = CRC16_INIT;
                        reject_run = '0;
                        if ((crc32_committed ^ CRC32_INIT) == file_crc_exp) begin
                            rx_mode = M_DONE;
                            expect_result(t_result'{REPLY_APPROVE, ST_FRAG_OK, 1'b0});
                            expect_result(t_result'{REPLY_APPROVE, ST_DONE, 1'b1});
                        end else begin
                            expect_result(t_result'{REPLY_APPROVE, ST_FRAG_OK, 1'b1});
                        end
                    end else begin
                        // Drop the fragment and count the try
                        crc32_running = crc32_committed;
                        crc16_frag = CRC16_INIT;
                        if (reject_run != 8'hFF) reject_run++;
                        if (reject_run >= tries_cfg) begin
                            rx_mode = M_FAILED;
                            expect_result(t_result'{REPLY_REJECT, ST_FRAG_BAD, 1'b0});
                            expect_result(t_result'{REPLY_NONE, ST_TRIES, 1'b1});
                        end else begin
                            expect_result(t_result'{REPLY_REJECT, ST_FRAG_BAD, 1'b1});
                        end
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_reply();
        t_result want;
        if (expected_replies.size() == 0) begin
            report_error($sformatf("unexpected word: reply %0d status %0d last %0b",
                                   o_m_tdata[1:0], o_m_tdata[4:2], o_m_tlast));
        end else begin
            want = expected_replies.pop_front();
            if (o_m_tdata[1:0] !== want.reply || o_m_tdata[4:2] !== want.status ||
                o_m_tlast !== want.last) begin
                report_error($sformatf(
                    "word mismatch: expected reply %0d status %0d last %0b, got %0d %0d %0b",
                    want.reply, want.status, want.last,
                    o_m_tdata[1:0], o_m_tdata[4:2], o_m_tlast));
            end
        end
    endfunction

    task automatic queue_word(logic [1:0] cmd, logic [7:0] b, logic [31:0] v);
        pending_words.insert(pending_words.size(), t_word'{cmd, b, v});
        words_queued++;
    endtask

    // Header commands, which the block drops once it is past the headers
    task automatic queue_noise();
        queue_word(2'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic pick_fragment_bytes();
        int len;
        frag_bytes.delete();
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        repeat (len) frag_bytes.insert(frag_bytes.size(), 8'($urandom_range(0, 255)));
    endtask

    // Queue the bytes of frag_bytes and a claimed CRC-16 of the given kind
    task automatic send_fragment(int kind);
        logic [15:0] crc;
        logic [31:0] claim;
        crc = CRC16_INIT;
        foreach (frag_bytes[i]) begin
            crc = crc16_update(crc, frag_bytes[i]);
            queue_word(CMD_BYTE, frag_bytes[i], $urandom);
            if ($urandom_range(0, 15) == 0) queue_noise();
        end
        claim = {16'h0, crc};
        if (kind == FRAG_FLIP) claim[15:0] = crc ^ 16'($urandom_range(1, 16'hFFFF));
        else if (kind == FRAG_WIDE) claim[31:16] = 16'($urandom_range(1, 16'hFFFF));
        queue_word(CMD_CHECK, 8'($urandom_range(0, 255)), claim);
    endtask

    // Random fragments; keep consecutive rejects below run_cap + 1
    task automatic run_random_phase(int n_words, int run_cap, int bad_pct);
        int done_words;
        int run;
        int burst;
        int kind;
        done_words = 0;
        run = int'(reject_run);
        burst = 0;
        while (done_words < n_words) begin
            if (burst == 0 && $urandom_range(0, 59) == 0) burst = $urandom_range(5, 40);
            kind = FRAG_GOOD;
            if (run < run_cap && (burst > 0 || $urandom_range(0, 99) < bad_pct))
                kind = ($urandom_range(0, 1) != 0) ? FRAG_FLIP : FRAG_WIDE;
            if (burst > 0) burst--;
            run = (kind == FRAG_GOOD) ? 0 : run + 1;
            pick_fragment_bytes();
            done_words += frag_bytes.size() + 1;
            send_fragment(kind);
        end
    endtask

    task automatic write_max_tries(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tries_cfg = v;
    endtask

    // Hold until every queued word is taken and every result word has come
    task automatic wait_drained();
        while (words_taken != words_queued || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: present queued words with random gaps, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_word(tx_word);
                words_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    tx_word = pending_words.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {tx_word.value, tx_word.data_b};
                    i_s_tuser  <= tx_word.cmd;
                    if (tx_quiet > 0) begin
                        tx_quiet--;
                        tx_gap = 0;
                    end else begin
                        if ($urandom_range(0, 39) == 0) tx_quiet = $urandom_range(20, 80);
                        tx_gap = pick_gap();
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check result words, stall at random, hold off once for long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_reply();
            if (hold_arm && !hold_used) begin
                hold_used = 1'b1;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (rx_quiet > 0) begin
                    rx_quiet--;
                end else if ($urandom_range(0, 3) == 0) begin
                    rx_stall = pick_gap();
                    if ($urandom_range(0, 29) == 0) rx_quiet = $urandom_range(20, 80);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [31:0] hdr;
        logic [31:0] steer;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_max_tries(MAX_TRIES_RST);

        hdr = $urandom;
        if (hdr == 32'h0) hdr = 32'h1;

        // Words out of turn before and between the headers are dropped
        queue_word(CMD_CHECK, 8'hFF, 32'h0000_FFFF);
        queue_word(CMD_BYTE, 8'hFF, 32'hFFFF_FFFF);
        queue_word(CMD_FCRC, 8'h00, 32'h0000_0001);
        queue_word(CMD_SIZE, 8'h00, 32'hFFFF_FFFF);
        queue_word(CMD_SIZE, 8'hFF, 32'h0);
        queue_word(CMD_BYTE, 8'h00, 32'h0);
        queue_word(CMD_CHECK, 8'h00, 32'hFFFF_FFFF);
        queue_word(CMD_FCRC, 8'hA5, hdr);
        queue_word(CMD_FCRC, 8'h5A, 32'h0);
        queue_word(CMD_SIZE, 8'h00, 32'h0);
        // Empty fragment, then a wide claim whose low half would match
        queue_word(CMD_CHECK, 8'h00, {16'h0, CRC16_INIT});
        queue_word(CMD_CHECK, 8'h00, {16'h0001, CRC16_INIT});
        // Four rejects in a row stay under the reset try limit, then commit
        frag_bytes = '{8'h00};
        send_fragment(FRAG_FLIP);
        frag_bytes = '{8'hFF};
        send_fragment(FRAG_WIDE);
        frag_bytes = '{8'h00, 8'hFF};
        send_fragment(FRAG_FLIP);
        frag_bytes = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
        send_fragment(FRAG_GOOD);
        wait_drained();

        // Largest try limit, many rejects; receiver holds off once meanwhile
        write_max_tries(8'd255);
        run_random_phase(550, 254, 45);
        hold_arm <= 1'b1;
        wait_drained();

        // Smallest try limit: clean fragments only
        write_max_tries(8'd1);
        run_random_phase(200, 0, 0);
        wait_drained();

        write_max_tries(8'($urandom_range(2, 20)));
        run_random_phase(400, tries_cfg - 1, 40);
        wait_drained();

        if ($urandom_range(0, 1) != 0) begin
            // Steer the committed CRC onto the header checksum to finish
            steer = crc32_steer(crc32_committed, file_crc_exp ^ CRC32_INIT);
            frag_bytes = '{steer[7:0], steer[15:8], steer[23:16], steer[31:24]};
            send_fragment(FRAG_GOOD);
        end else begin
            // Reject until the try limit ends the transfer
            write_max_tries(8'($urandom_range(1, 40)));
            repeat (tries_cfg) begin
                pick_fragment_bytes();
                send_fragment(($urandom_range(0, 1) != 0) ? FRAG_FLIP : FRAG_WIDE);
            end
        end
        wait_drained();

        // Terminal mode: everything is dropped
        repeat (20) begin
            queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
        end
        wait_drained();

        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
